// ===== rtl/compass_sentence_parser_assert.svh =====
// Assertion helpers for the compass sentence parser.
// Both expect i_clk and i_rst_n in scope.
`ifndef COMPASS_SENTENCE_PARSER_ASSERT_SVH
`define COMPASS_SENTENCE_PARSER_ASSERT_SVH

`define CSP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define CSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/csp_pkg.sv =====
package csp_pkg;

    localparam int VALUE_BITS_DEF = 32;

    typedef logic [3:0] t_kind;

    localparam t_kind KIND_HEADING = 4'd0;
    localparam t_kind KIND_PITCH   = 4'd1;
    localparam t_kind KIND_ROLL    = 4'd2;
    localparam t_kind KIND_X       = 4'd3;
    localparam t_kind KIND_Y       = 4'd4;
    localparam t_kind KIND_Z       = 4'd5;
    localparam t_kind KIND_TEMP    = 4'd6;
    localparam t_kind KIND_ERROR   = 4'd7;
    localparam t_kind KIND_END     = 4'd8;
    localparam t_kind KIND_NONE    = 4'd15;

    localparam logic [2:0] FRAC_RESET = 3'd3;
    localparam logic [2:0] FRAC_MAX   = 3'd6;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_X      = 8'h58;
    localparam logic [7:0] CH_Y      = 8'h59;
    localparam logic [7:0] CH_Z      = 8'h5A;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_E      = 8'h45;

    // close request control, travels parser -> scaler
    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [2:0] shift;
        logic       neg;
        logic       ok;
    } t_req;

    function automatic t_kind key_of(logic [7:0] b);
        case (b)
            CH_C:    return KIND_HEADING;
            CH_P:    return KIND_PITCH;
            CH_R:    return KIND_ROLL;
            CH_X:    return KIND_X;
            CH_Y:    return KIND_Y;
            CH_Z:    return KIND_Z;
            CH_T:    return KIND_TEMP;
            CH_E:    return KIND_ERROR;
            default: return KIND_NONE;
        endcase
    endfunction

    function automatic logic is_hex(logic [7:0] b);
        return (b inside {[CH_0:CH_9], [CH_UA:CH_UF], [CH_LA:CH_LF]});
    endfunction

    function automatic logic [3:0] hex_val(logic [7:0] b);
        logic [7:0] t;
        t = 8'd0;
        if (b inside {[CH_0:CH_9]}) begin
            t = b - CH_0;
        end else if (b inside {[CH_UA:CH_UF]}) begin
            t = b - CH_UA + 8'd10;
        end else if (b inside {[CH_LA:CH_LF]}) begin
            t = b - CH_LA + 8'd10;
        end
        return t[3:0];
    endfunction

    function automatic logic [19:0] pow10(logic [2:0] k);
        case (k)
            3'd0:    return 20'd1;
            3'd1:    return 20'd10;
            3'd2:    return 20'd100;
            3'd3:    return 20'd1000;
            3'd4:    return 20'd10000;
            3'd5:    return 20'd100000;
            3'd6:    return 20'd1000000;
            default: return 20'd1000000;
        endcase
    endfunction

    // largest magnitude that can take k more decimal shifts without saturating
    function automatic logic [7:0][63:0] csp_limits(int vb);
        logic [7:0][63:0] t;
        logic [63:0]      m;
        m = (64'd1 << (vb - 1)) - 64'd1;
        for (int i = 0; i < 8; i++) begin
            t[i] = m;
            if (i < 6) m = m / 10;
        end
        return t;
    endfunction

endpackage

// ===== rtl/csp_if.sv =====
interface csp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface csp_result_if;
    logic               valid;
    logic               ready;
    logic [3:0]         field_kind;
    logic signed [31:0] field_value;
    logic               checksum_ok;

    modport source (output valid, output field_kind, output field_value,
                    output checksum_ok, input ready);
    modport sink   (input valid, input field_kind, input field_value,
                    input checksum_ok, output ready);
endinterface

interface csp_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] fraction_digits;

    modport source (output valid, output fraction_digits, input ready);
    modport sink   (input valid, input fraction_digits, output ready);
endinterface

// ===== rtl/compass_sentence_parser.sv =====
// Compass sentence parser.
// i_rx carries one received character per request. o_res carries one result
// per closed field (kind, signed fixed-point value or 16-bit error word) and
// one per sentence end (kind 8, value 0, checksum_ok).
// i_cfg writes fraction_digits (0..7, values above 6 act as 6, reset 3); it
// is always ready and is to be written only while the parser is idle.
// Throughput: one character per cycle while o_res is not stalled. The parser
// state updates at the accepting edge; a result then reaches o_res through
// the 32x20 partial-product stage and the sum/saturate/negate stage.
// The whole pipeline advances when the output register is empty or taken,
// so i_rx.ready drops only while o_res is stalled; nothing is lost.
// Synchronous active-low reset clears the parser state, empties the
// pipeline and sets fraction_digits to 3.
module compass_sentence_parser
    import csp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    csp_byte_if.sink     i_rx,
    csp_cfg_if.sink      i_cfg,
    csp_result_if.source o_res
);

`include "compass_sentence_parser_assert.svh"

    logic                  w_adv;
    logic                  w_fire;
    t_req                  w_req;
    logic [VALUE_BITS-1:0] w_acc;
    logic                  w_valid;

    assign w_adv      = !w_valid || o_res.ready;
    assign w_fire     = i_rx.valid && w_adv;
    assign i_rx.ready = w_adv;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = w_valid;

    csp_parse #(
        .VALUE_BITS(VALUE_BITS)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_fire     (w_fire),
        .i_byte     (i_rx.rx_byte),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.fraction_digits),
        .o_req      (w_req),
        .o_acc      (w_acc)
    );

    csp_scale #(
        .VALUE_BITS(VALUE_BITS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_req   (w_req),
        .i_acc   (w_acc),
        .o_valid (w_valid),
        .o_kind  (o_res.field_kind),
        .o_value (o_res.field_value),
        .o_ok    (o_res.checksum_ok)
    );

    `CSP_ASSERT_IMP(a_end_zero, o_res.valid && o_res.field_kind == KIND_END, o_res.field_value == 32'sd0, "sentence end with nonzero value")
    `CSP_ASSERT_IMP(a_field_ok_low, o_res.valid && o_res.field_kind != KIND_END, !o_res.checksum_ok, "field result with checksum flag")
    `CSP_ASSERT_IMP(a_ready_rule, 1'b1, i_rx.ready == (!o_res.valid || o_res.ready), "input ready out of step with output")
    `CSP_ASSERT_NEXT(a_dollar_quiet, i_rx.valid && i_rx.ready && i_rx.rx_byte == CH_DOLLAR, !w_req.valid, "dollar produced a request")

endmodule

// ===== rtl/csp_parse.sv =====
module csp_parse
    import csp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_fire,
    input  logic [7:0]            i_byte,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_data,
    output t_req                  o_req,
    output logic [VALUE_BITS-1:0] o_acc
);

    localparam logic [VALUE_BITS-1:0] MAG_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    logic [2:0]            r_frac, n_frac;
    logic                  r_in, n_in;
    logic [7:0]            r_xor, n_xor;
    t_kind                 r_key, n_key;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic                  r_neg, n_neg;
    logic                  r_seen, n_seen;
    logic [2:0]            r_fc, n_fc;
    logic [1:0]            r_cd, n_cd;
    logic [7:0]            r_rc, n_rc;
    t_req                  r_req, n_req;
    logic [VALUE_BITS-1:0] r_racc, n_racc;

    logic                  w_hex;
    logic [3:0]            w_hv;
    t_kind                 w_key;
    logic                  w_digit;
    logic [3:0]            w_dv;
    logic [2:0]            w_kept;
    logic [2:0]            w_shift;
    logic                  w_dec;
    logic [VALUE_BITS+3:0] w_m10;
    logic [VALUE_BITS-1:0] w_macc;
    t_req                  w_close;

    assign w_hex   = is_hex(i_byte);
    assign w_hv    = hex_val(i_byte);
    assign w_key   = key_of(i_byte);
    assign w_digit = (i_byte inside {[CH_0:CH_9]});
    assign w_dv    = w_hv;
    assign w_kept  = (r_frac > FRAC_MAX) ? FRAC_MAX : r_frac;
    assign w_shift = (r_fc < w_kept) ? (w_kept - r_fc) : 3'd0;
    assign w_dec   = (r_key != KIND_NONE) && (r_key != KIND_ERROR);

    // saturating acc*10 + digit
    assign w_m10  = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1)
                  + (VALUE_BITS+4)'(w_dv);
    assign w_macc = (w_m10 > {4'd0, MAG_MAX}) ? MAG_MAX : w_m10[VALUE_BITS-1:0];

    always_comb begin
        w_close.valid = (r_key != KIND_NONE);
        w_close.kind  = r_key;
        w_close.shift = (r_key == KIND_ERROR) ? 3'd0 : w_shift;
        w_close.neg   = (r_key != KIND_ERROR) && r_neg;
        w_close.ok    = 1'b0;
    end

    always_comb begin
        n_frac = i_cfg_we ? i_cfg_data : r_frac;
        n_in   = r_in;
        n_xor  = r_xor;
        n_key  = r_key;
        n_acc  = r_acc;
        n_neg  = r_neg;
        n_seen = r_seen;
        n_fc   = r_fc;
        n_cd   = r_cd;
        n_rc   = r_rc;
        n_req  = '0;
        n_racc = r_acc;

        if (i_fire) begin
            if (i_byte == CH_DOLLAR) begin
                n_in   = 1'b1;
                n_xor  = 8'd0;
                n_cd   = 2'd0;
                n_rc   = 8'd0;
                n_key  = KIND_NONE;
                n_acc  = '0;
                n_neg  = 1'b0;
                n_seen = 1'b0;
                n_fc   = 3'd0;
            end else if (!r_in) begin
                n_in = r_in;
            end else if (r_cd != 2'd0) begin
                if (w_hex) begin
                    if (r_cd == 2'd1) begin
                        n_rc = {4'd0, w_hv};
                        n_cd = 2'd2;
                    end else begin
                        n_rc        = {r_rc[3:0], w_hv};
                        n_req.valid = 1'b1;
                        n_req.kind  = KIND_END;
                        n_req.ok    = ({r_rc[3:0], w_hv} == r_xor);
                        n_racc      = '0;
                        n_in        = 1'b0;
                        n_cd        = 2'd0;
                    end
                end
            end else if (i_byte == CH_STAR) begin
                n_req = w_close;
                n_key = KIND_NONE;
                n_cd  = 2'd1;
                n_rc  = 8'd0;
            end else begin
                n_xor = r_xor ^ i_byte;
                if (r_key == KIND_ERROR && w_hex) begin
                    n_acc = VALUE_BITS'({r_acc[11:0], w_hv});
                end else if (w_key != KIND_NONE) begin
                    n_req  = w_close;
                    n_key  = w_key;
                    n_acc  = '0;
                    n_neg  = 1'b0;
                    n_seen = 1'b0;
                    n_fc   = 3'd0;
                end else if (w_dec && (w_digit || i_byte == CH_MINUS
                             || i_byte == CH_PLUS || i_byte == CH_POINT)) begin
                    if (w_digit) begin
                        if (!r_seen) begin
                            n_acc = w_macc;
                        end else if (r_fc < w_kept) begin
                            n_acc = w_macc;
                            n_fc  = r_fc + 3'd1;
                        end
                    end else if (i_byte == CH_MINUS) begin
                        n_neg = 1'b1;
                    end else if (i_byte == CH_POINT) begin
                        n_seen = 1'b1;
                    end
                end else begin
                    n_req = w_close;
                    n_key = KIND_NONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac <= FRAC_RESET;
            r_in   <= 1'b0;
            r_xor  <= 8'd0;
            r_key  <= KIND_NONE;
            r_acc  <= '0;
            r_neg  <= 1'b0;
            r_seen <= 1'b0;
            r_fc   <= 3'd0;
            r_cd   <= 2'd0;
            r_rc   <= 8'd0;
            r_req  <= '0;
        end else begin
            r_frac <= n_frac;
            r_in   <= n_in;
            r_xor  <= n_xor;
            r_key  <= n_key;
            r_acc  <= n_acc;
            r_neg  <= n_neg;
            r_seen <= n_seen;
            r_fc   <= n_fc;
            r_cd   <= n_cd;
            r_rc   <= n_rc;
            if (i_adv) begin
                r_req <= n_req;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_racc <= n_racc;
        end
    end

    assign o_req = r_req;
    assign o_acc = r_racc;

endmodule

// ===== rtl/csp_scale.sv =====
module csp_scale
    import csp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  t_req                  i_req,
    input  logic [VALUE_BITS-1:0] i_acc,
    output logic                  o_valid,
    output t_kind                 o_kind,
    output logic signed [31:0]    o_value,
    output logic                  o_ok
);

    localparam int HALF = (VALUE_BITS + 1) / 2;
    localparam int HIGH = VALUE_BITS - HALF;
    localparam int WX   = (VALUE_BITS > 32) ? VALUE_BITS : 32;
    localparam logic [VALUE_BITS-1:0] MAG_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [7:0][63:0] LIMITS = csp_limits(VALUE_BITS);

    logic [19:0]            w_pow;
    logic [VALUE_BITS-1:0]  w_lim;
    logic                   w_sat;
    logic [HALF+19:0]       w_pp_lo;
    logic [HIGH+19:0]       w_pp_hi;

    t_req                   r_ctl;
    logic                   r_sat;
    logic [HALF+19:0]       r_pp_lo;
    logic [HIGH+19:0]       r_pp_hi;

    logic [VALUE_BITS+19:0] w_sum;
    logic [VALUE_BITS-1:0]  w_mag;
    logic [WX-1:0]          w_ext;
    logic [WX-1:0]          w_sgn;

    logic                   r_o_valid;
    t_kind                  r_o_kind;
    logic signed [31:0]     r_o_value;
    logic                   r_o_ok;

    assign w_pow   = pow10(i_req.shift);
    assign w_lim   = LIMITS[i_req.shift][VALUE_BITS-1:0];
    assign w_sat   = (i_req.kind < KIND_ERROR) && (i_acc > w_lim);
    assign w_pp_lo = {20'd0, i_acc[HALF-1:0]} * {{HALF{1'b0}}, w_pow};
    assign w_pp_hi = {20'd0, i_acc[VALUE_BITS-1:HALF]} * {{HIGH{1'b0}}, w_pow};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sat   <= w_sat;
            r_pp_lo <= w_pp_lo;
            r_pp_hi <= w_pp_hi;
        end
    end

    assign w_sum = (VALUE_BITS+20)'(r_pp_lo) + ((VALUE_BITS+20)'(r_pp_hi) << HALF);
    assign w_mag = r_sat ? MAG_MAX : w_sum[VALUE_BITS-1:0];
    assign w_ext = WX'(w_mag);
    assign w_sgn = r_ctl.neg ? (~w_ext + WX'(1)) : w_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_adv) begin
            r_o_valid <= r_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_o_kind  <= r_ctl.kind;
            r_o_value <= w_sgn[31:0];
            r_o_ok    <= r_ctl.ok;
        end
    end

    assign o_valid = r_o_valid;
    assign o_kind  = r_o_kind;
    assign o_value = r_o_value;
    assign o_ok    = r_o_ok;

endmodule

// ===== dv/compass_sentence_parser_checker.sv =====
`timescale 1ns / 1ps

module compass_sentence_parser_checker
    import csp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    csp_byte_if          i_rx,
    csp_cfg_if           i_cfg,
    csp_result_if        i_res,
    output int           o_mismatches,
    output int           o_outstanding
);

    localparam logic [63:0] MAG_LIMIT = (64'd1 << (VALUE_BITS_DEF - 1)) - 64'd1;

    typedef struct {
        t_kind       kind;
        logic [31:0] value;
        logic        ok;
    } field_result_t;

    field_result_t field_q[$];
    field_result_t want;
    int            mismatches = 0;

    logic [2:0]  frac_digits;
    bit          in_sentence;
    logic [7:0]  xor_sum;
    t_kind       open_key;
    logic [63:0] mag;
    bit          minus;
    bit          point_seen;
    int          frac_held;
    int          cks_state;   // 0 body, 1 first digit, 2 second digit
    logic [7:0]  cks_value;

    function automatic logic [63:0] shift_in_digit(logic [63:0] a, logic [63:0] d);
        if (a > (MAG_LIMIT - d) / 64'd10) return MAG_LIMIT;
        return a * 64'd10 + d;
    endfunction

    // bit 4 set: not a hex character
    function automatic logic [4:0] hex_digit(logic [7:0] b);
        logic [7:0] t;
        t = 8'd0;
        if (b >= CH_0 && b <= CH_9) begin
            t = b - CH_0;
        end else if (b >= CH_UA && b <= CH_UF) begin
            t = b - CH_UA + 8'd10;
        end else if (b >= CH_LA && b <= CH_LF) begin
            t = b - CH_LA + 8'd10;
        end else begin
            return 5'h10;
        end
        return {1'b0, t[3:0]};
    endfunction

    function automatic t_kind key_for(logic [7:0] b);
        case (b)
            CH_C:    return KIND_HEADING;
            CH_P:    return KIND_PITCH;
            CH_R:    return KIND_ROLL;
            CH_X:    return KIND_X;
            CH_Y:    return KIND_Y;
            CH_Z:    return KIND_Z;
            CH_T:    return KIND_TEMP;
            CH_E:    return KIND_ERROR;
            default: return KIND_NONE;
        endcase
    endfunction

    function automatic int frac_limit();
        int n;
        if (frac_digits > FRAC_MAX) n = int'(FRAC_MAX);
        else n = int'(frac_digits);
        return n;
    endfunction

    function void open_field(t_kind k);
        open_key   = k;
        mag        = 64'd0;
        minus      = 1'b0;
        point_seen = 1'b0;
        frac_held  = 0;
    endfunction

    function void close_field();
        logic [63:0]   v;
        field_result_t r;
        if (open_key == KIND_NONE) return;
        if (open_key == KIND_ERROR) begin
            v = mag & 64'hFFFF;
        end else begin
            for (int k = frac_held; k < frac_limit(); k++) mag = shift_in_digit(mag, 64'd0);
            v = minus ? (64'd0 - mag) : mag;
        end
        r.kind  = open_key;
        r.value = v[31:0];
        r.ok    = 1'b0;
        field_q.push_back(r);
        open_key = KIND_NONE;
    endfunction

    function void take_byte(logic [7:0] b);
        logic [4:0]    h;
        t_kind         k;
        field_result_t r;
        h = hex_digit(b);
        k = key_for(b);
        if (b == CH_DOLLAR) begin
            in_sentence = 1'b1;
            xor_sum     = 8'd0;
            cks_state   = 0;
            cks_value   = 8'd0;
            open_field(KIND_NONE);
            return;
        end
        if (!in_sentence) return;
        if (cks_state != 0) begin
            if (h[4]) return;
            if (cks_state == 1) begin
                cks_value = {4'd0, h[3:0]};
                cks_state = 2;
                return;
            end
            cks_value = {cks_value[3:0], h[3:0]};
            r.kind  = KIND_END;
            r.value = 32'd0;
            r.ok    = (cks_value == xor_sum);
            field_q.push_back(r);
            in_sentence = 1'b0;
            cks_state   = 0;
            return;
        end
        if (b == CH_STAR) begin
            close_field();
            cks_state = 1;
            cks_value = 8'd0;
            return;
        end
        xor_sum = xor_sum ^ b;
        if (open_key == KIND_ERROR && !h[4]) begin
            mag = {mag[59:0], h[3:0]} & 64'hFFFF;
            return;
        end
        if (k != KIND_NONE) begin
            close_field();
            open_field(k);
            return;
        end
        if (open_key != KIND_NONE && open_key != KIND_ERROR) begin
            if (b >= CH_0 && b <= CH_9) begin
                if (!point_seen) begin
                    mag = shift_in_digit(mag, {56'd0, b - CH_0});
                end else if (frac_held < frac_limit()) begin
                    mag = shift_in_digit(mag, {56'd0, b - CH_0});
                    frac_held++;
                end
                return;
            end
            if (b == CH_MINUS) begin
                minus = 1'b1;
                return;
            end
            if (b == CH_PLUS) return;
            if (b == CH_POINT) begin
                point_seen = 1'b1;
                return;
            end
        end
        close_field();
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frac_digits = FRAC_RESET;
            in_sentence = 1'b0;
            xor_sum     = 8'd0;
            cks_state   = 0;
            cks_value   = 8'd0;
            open_field(KIND_NONE);
            field_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) frac_digits = i_cfg.fraction_digits;
            if (i_rx.valid && i_rx.ready) take_byte(i_rx.rx_byte);
            if (i_res.valid && i_res.ready) begin
                if (field_q.size() == 0) begin
                    mismatches++;
                    $display("%0t unexpected result: expected none, actual %0d %0d %0b",
                             $time, i_res.field_kind, $signed(i_res.field_value),
                             i_res.checksum_ok);
                end else begin
                    want = field_q.pop_front();
                    if (i_res.field_kind !== want.kind || i_res.field_value !== want.value ||
                        i_res.checksum_ok !== want.ok) begin
                        mismatches++;
                        $display("%0t mismatch: expected %0d %0d %0b, actual %0d %0d %0b",
                                 $time, want.kind, $signed(want.value), want.ok,
                                 i_res.field_kind, $signed(i_res.field_value),
                                 i_res.checksum_ok);
                    end
                end
            end
        end
        o_outstanding <= field_q.size();
        o_mismatches  <= mismatches;
    end

endmodule

// ===== dv/compass_sentence_parser_tb.sv =====
`timescale 1ns / 1ps

module compass_sentence_parser_tb;
    import csp_pkg::*;

    localparam int         ITEM_TARGET    = 1650;
    localparam int         QUIET_ENDS_AT  = 1350;
    localparam int         DRAIN_CYCLES   = 6;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam logic [7:0] CH_COMMA       = 8'h2C;

    logic i_clk = 1'b0;
    logic i_rst_n;

    csp_byte_if   rx_chan();
    csp_cfg_if    cfg_chan();
    csp_result_if res_chan();

    int mismatches;
    int outstanding;

    bit         gaps_on   = 1'b0;
    bit         stalls_on = 1'b0;
    int         stall_left = 0;
    int         quiet_cycles = 0;
    int         sent = 0;
    int         cfg_writes = 0;
    int         sentence_no = 0;
    int         mid;
    logic [7:0] frame[$];

    compass_sentence_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_chan),
        .i_cfg   (cfg_chan),
        .o_res   (res_chan)
    );

    compass_sentence_parser_checker field_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx          (rx_chan),
        .i_cfg         (cfg_chan),
        .i_res         (res_chan),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left     <= stall_left - 1;
            res_chan.ready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            stall_left     <= $urandom_range(0, 15);
            res_chan.ready <= 1'b0;
        end else begin
            res_chan.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((rx_chan.valid && rx_chan.ready) || (cfg_chan.valid && cfg_chan.ready) ||
            (res_chan.valid && res_chan.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            rx_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        rx_chan.valid   <= 1'b1;
        rx_chan.rx_byte <= b;
        @(posedge i_clk);
        while (rx_chan.ready !== 1'b1) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // hold off requests until every pending result is out
    task automatic drain_results();
        rx_chan.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_frac(input logic [2:0] v);
        drain_results();
        cfg_chan.valid           <= 1'b1;
        cfg_chan.fraction_digits <= v;
        @(posedge i_clk);
        while (cfg_chan.ready !== 1'b1) @(posedge i_clk);
        cfg_chan.valid <= 1'b0;
        cfg_writes++;
    endtask

    function automatic logic [2:0] next_frac();
        case (cfg_writes)
            0:       return 3'd0;
            1:       return FRAC_MAX;
            2:       return 3'd7;
            default: return 3'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v, bit lower);
        logic [7:0] w;
        w = {4'd0, v};
        if (v < 4'd10) return CH_0 + w;
        return (lower ? CH_LA : CH_UA) + w - 8'd10;
    endfunction

    function automatic logic [7:0] key_char(int k);
        case (k)
            0:       return CH_C;
            1:       return CH_P;
            2:       return CH_R;
            3:       return CH_X;
            4:       return CH_Y;
            5:       return CH_Z;
            6:       return CH_T;
            default: return CH_E;
        endcase
    endfunction

    function void add_digits(int n);
        logic [7:0] d;
        for (int i = 0; i < n; i++) begin
            d = 8'($urandom_range(0, 9));
            frame.push_back(CH_0 + d);
        end
    endfunction

    function void add_field();
        int k;
        int r;
        k = $urandom_range(0, 7);
        frame.push_back(key_char(k));
        if (key_char(k) == CH_E) begin
            r = $urandom_range(0, 6);
            for (int i = 0; i < r; i++)
                frame.push_back(hex_char(4'($urandom_range(0, 15)),
                                         1'($urandom_range(0, 1))));
            return;
        end
        r = $urandom_range(0, 9);
        if (r == 0) frame.push_back(CH_MINUS);
        else if (r == 1) frame.push_back(CH_PLUS);
        if ($urandom_range(0, 15) == 0) add_digits($urandom_range(8, 14));
        else add_digits($urandom_range(0, 4));
        if ($urandom_range(0, 3) != 0) begin
            frame.push_back(CH_POINT);
            add_digits($urandom_range(0, 8));
            if ($urandom_range(0, 11) == 0) begin
                frame.push_back(CH_POINT);
                add_digits(1);
            end
        end
        if ($urandom_range(0, 19) == 0) frame.push_back(CH_MINUS);
    endfunction

    function void build_sentence();
        int         fields;
        int         cut;
        logic [7:0] sum;
        logic [7:0] b;
        frame.delete();
        if ($urandom_range(0, 4) == 0) begin
            for (int i = $urandom_range(1, 3); i > 0; i--) begin
                frame.push_back(8'($urandom_range(0, 255)));
            end
        end
        frame.push_back(CH_DOLLAR);
        if ($urandom_range(0, 7) == 0) add_digits(1);
        fields = $urandom_range(1, 9);
        for (int i = 0; i < fields; i++) begin
            if ($urandom_range(0, 14) == 0) frame.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 5) == 0) frame.push_back(CH_COMMA);
            add_field();
        end
        sum = 8'd0;
        for (int i = 0; i < frame.size(); i++) begin
            if (frame[i] == CH_DOLLAR) sum = 8'd0;
            else sum = sum ^ frame[i];
        end
        frame.push_back(CH_STAR);
        if ($urandom_range(0, 7) == 0) begin
            b = 8'($urandom_range(0, 127));
            frame.push_back($urandom_range(0, 1) ? CH_X : (8'h80 | b));
        end
        if ($urandom_range(0, 5) == 0) sum = sum ^ 8'($urandom_range(1, 255));
        frame.push_back(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
        frame.push_back(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, frame.size() - 1);
            while (frame.size() > cut) void'(frame.pop_back());
        end
    endfunction

    initial begin
        rx_chan.valid            <= 1'b0;
        rx_chan.rx_byte          <= 8'd0;
        cfg_chan.valid           <= 1'b0;
        cfg_chan.fraction_digits <= 3'd0;
        i_rst_n                  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("$C-1.2.5P+E1cE5ARX.$Y9#ZT*g42");

        while (sent < ITEM_TARGET) begin
            gaps_on   = (sent < QUIET_ENDS_AT) && !(sent >= 600 && sent < 800);
            stalls_on = gaps_on;
            if (sentence_no % 7 == 0) write_frac(next_frac());
            build_sentence();
            mid = -1;
            if ($urandom_range(0, 11) == 0 && frame.size() > 3)
                mid = $urandom_range(2, frame.size() - 1);
            for (int i = 0; i < frame.size(); i++) begin
                if (i == mid) write_frac(next_frac());
                send_byte(frame[i]);
            end
            sentence_no++;
        end

        drain_results();
        if (mismatches == 0 && outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
